### design/sha256_stream_hasher_defines.svh
// ---------------------------------------------------------------------------
// sha256_stream_hasher_defines.svh
// Assertion macros shared by the hasher RTL.
// ---------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, off during reset
`define SHS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("shs: same-cycle check failed");
// next-cycle implication, off during reset
`define SHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("shs: next-cycle check failed");
`else
`define SHS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### design/shs_pkg.sv
// ---------------------------------------------------------------------------
// shs_pkg
// Beat types, sequencer states, round constants and SHA-256 bit functions.
// ---------------------------------------------------------------------------
package shs_pkg;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       has_byte;
		logic       end_of_message;
	} shs_in_beat_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} shs_out_beat_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_COMP = 5'b00010,
		ST_FOLD = 5'b00100,
		ST_PAD  = 5'b01000,
		ST_OUT  = 5'b10000
	} shs_state_t;

	localparam int unsigned HashWords  = 8;
	localparam int unsigned BlockWords = 16;
	localparam int unsigned NumRounds  = 64;

	localparam logic [7:0]  PadMarker   = 8'h80;
	localparam logic [5:0]  LenStart    = 6'd56;
	localparam logic [5:0]  LastByte    = 6'd63;
	localparam logic [5:0]  LastRound   = 6'd63;
	localparam logic [2:0]  LastWordIdx = 3'd7;
	localparam logic [63:0] BitsPerByte = 64'd8;

	localparam logic [31:0] RoundK [NumRounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] InitH [HashWords] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	function automatic logic [31:0] ch_fn(input logic [31:0] e, input logic [31:0] f,
			input logic [31:0] g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] maj_fn(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

### design/shs_stream_if.sv
// ---------------------------------------------------------------------------
// shs_stream_if
// Valid/ready channels of the hasher: message byte beats and digest beats.
// ---------------------------------------------------------------------------
interface shs_byte_if;
	import shs_pkg::*;

	logic         valid;
	logic         ready;
	shs_in_beat_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface shs_digest_if;
	import shs_pkg::*;

	logic          valid;
	logic          ready;
	shs_out_beat_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

### design/sha256_stream_hasher.sv
// ---------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream with one round unit shared by all 64 rounds.
// ---------------------------------------------------------------------------
// Usage:
//   msg_in carries one beat per item: an optional message byte (has_byte)
//   and an end-of-message flag. digest_out gives eight beats per message,
//   digest words H0..H7 with word_index 0..7, last_word set on the eighth.
//   A beat without byte and without end of message is taken and ignored.
// Block flow:
//   A byte that does not fill the 64-byte block is taken while msg_in.ready
//   stays high. The 64th byte starts a compression: 64 rounds of the shared
//   round unit, then a fold into the chaining words, during which
//   msg_in.ready is low, so no byte is taken until the fold is done.
//   End of message: padding bytes (up to 72) are shifted in one per cycle,
//   pausing while each padded block (one or two) is compressed; then the
//   eight digest beats leave at one per cycle when the receiver is ready.
// Reset:
//   arst_n clears the sequencer and loads the initial hash values; the
//   block is ready for a beat as soon as reset is released.
// Stall:
//   digest_out holds one registered beat; while the receiver stalls the
//   sequencer waits in its output state and msg_in.ready stays low. After
//   the eighth word is registered the block takes new input again.
// ---------------------------------------------------------------------------
`include "sha256_stream_hasher_defines.svh"

module sha256_stream_hasher (
	input  logic                clk,
	input  logic                arst_n,
	shs_byte_if.sink            msg_in,
	shs_digest_if.source        digest_out
);
	import shs_pkg::*;

	// sequencer and message bookkeeping
	shs_state_t  state_q;
	logic [5:0]  fill_q;        // bytes in the current block
	logic [5:0]  rnd_q;         // round counter
	logic [63:0] len_q;         // message length in bits, wraps
	logic        in_pad_q;      // message ended, padding under way
	logic        pad_first_q;   // the 0x80 marker is still to go
	logic        tail_ok_q;     // length field fits in the current block
	logic        final_q;       // block under compression holds the length
	logic [2:0]  out_cnt_q;

	// datapath
	logic [31:0] h_q [HashWords];   // chaining words
	logic [31:0] v_q [HashWords];   // working variables a..h
	logic [31:0] w_q [BlockWords];  // byte buffer, then schedule window

	// output register
	logic          out_valid_q;
	shs_out_beat_t out_beat_q;

	logic        in_acc;
	logic        shift_en;
	logic [7:0]  shift_byte;
	logic [7:0]  len_byte;
	logic [7:0]  pad_byte;
	logic        blk_full;
	logic        out_load;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] w_new;

	assign msg_in.ready = (state_q == ST_IDLE);
	assign in_acc       = msg_in.valid & msg_in.ready;

	// length field goes out big-endian: byte 56 carries bits 63:56
	assign len_byte = len_q[{~fill_q[2:0], 3'b000} +: 8];
	assign pad_byte = pad_first_q ? PadMarker :
		((tail_ok_q && (fill_q >= LenStart)) ? len_byte : 8'h00);

	// one byte enters the buffer from the input or from the pad sequencer
	always_comb begin
		shift_en   = 1'b0;
		shift_byte = msg_in.payload.msg_byte;
		if (state_q == ST_IDLE) begin
			shift_en = in_acc & msg_in.payload.has_byte;
		end else if (state_q == ST_PAD) begin
			shift_en   = 1'b1;
			shift_byte = pad_byte;
		end
	end

	assign blk_full = shift_en && (fill_q == LastByte);

	// shared round unit and rolling message schedule
	assign t1 = v_q[7] + big_sig1(v_q[4]) + ch_fn(v_q[4], v_q[5], v_q[6])
		+ RoundK[rnd_q] + w_q[0];
	assign t2 = big_sig0(v_q[0]) + maj_fn(v_q[0], v_q[1], v_q[2]);
	assign w_new = small_sig1(w_q[14]) + w_q[9] + small_sig0(w_q[1]) + w_q[0];

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || digest_out.ready);

	// byte buffer doubles as the 16-word schedule window
	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int i = 0; i < BlockWords - 1; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i + 1][31:24]};
			end
			w_q[BlockWords - 1] <= {w_q[BlockWords - 1][23:0], shift_byte};
		end else if (state_q == ST_COMP) begin
			for (int i = 0; i < BlockWords - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[BlockWords - 1] <= w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (blk_full) begin
			v_q <= h_q;
		end else if (state_q == ST_COMP) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= InitH;
		end else if (state_q == ST_FOLD) begin
			for (int i = 0; i < HashWords; i++) begin
				h_q[i] <= h_q[i] + v_q[i];
			end
		end else if (out_load && (out_cnt_q == LastWordIdx)) begin
			h_q <= InitH;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			rnd_q       <= '0;
			len_q       <= '0;
			in_pad_q    <= 1'b0;
			pad_first_q <= 1'b0;
			tail_ok_q   <= 1'b0;
			final_q     <= 1'b0;
			out_cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (msg_in.payload.has_byte) begin
							fill_q <= fill_q + 6'd1;
							len_q  <= len_q + BitsPerByte;
						end
						if (msg_in.payload.end_of_message) begin
							in_pad_q    <= 1'b1;
							pad_first_q <= 1'b1;
						end
						if (blk_full) begin
							state_q <= ST_COMP;
							rnd_q   <= '0;
						end else if (msg_in.payload.end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == LastRound) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					if (final_q) begin
						state_q   <= ST_OUT;
						out_cnt_q <= '0;
					end else if (in_pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (pad_first_q) begin
						pad_first_q <= 1'b0;
						tail_ok_q   <= (fill_q < LenStart);
					end
					if (blk_full) begin
						state_q   <= ST_COMP;
						rnd_q     <= '0;
						final_q   <= !pad_first_q && tail_ok_q;
						tail_ok_q <= 1'b1;   // a fresh block always has room
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_cnt_q <= out_cnt_q + 3'd1;
						if (out_cnt_q == LastWordIdx) begin
							state_q   <= ST_IDLE;
							fill_q    <= '0;
							len_q     <= '0;
							in_pad_q  <= 1'b0;
							tail_ok_q <= 1'b0;
							final_q   <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// digest output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (digest_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_beat_q.digest_word <= h_q[out_cnt_q];
			out_beat_q.word_index  <= out_cnt_q;
			out_beat_q.last_word   <= (out_cnt_q == LastWordIdx);
		end
	end

	assign digest_out.valid   = out_valid_q;
	assign digest_out.payload = out_beat_q;

	`SHS_ASSERT_NEXT(a_rounds_end, clk, arst_n, state_q == ST_COMP && rnd_q == LastRound, state_q == ST_FOLD)
	`SHS_ASSERT_IMPL(a_comp_aligned, clk, arst_n, state_q == ST_COMP, fill_q == 6'd0)
	`SHS_ASSERT_IMPL(a_idle_clean, clk, arst_n, state_q == ST_IDLE, !in_pad_q && !final_q)
	`SHS_ASSERT_IMPL(a_out_final, clk, arst_n, state_q == ST_OUT, final_q && in_pad_q && fill_q == 6'd0)

endmodule
